/* hw/rtl/srb_pkg.sv */
package srb_pkg;

    localparam int WINDOW      = 16;
    localparam int SLOT_BITS   = $clog2(WINDOW);
    localparam int HANDLE_BITS = 16;
    localparam int SEQ_BITS    = 32;
    localparam int STATUS_BITS = 3;

    localparam int S_DATA_BITS = 48;
    localparam int S_USER_BITS = 1;
    localparam int M_DATA_BITS = 56;
    localparam int M_USER_BITS = 2;
    localparam int M_PAD_BITS  = M_DATA_BITS - SEQ_BITS - HANDLE_BITS - STATUS_BITS;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_IN_ORDER  = 3'd0,
        ST_STORED    = 3'd1,
        ST_LATE      = 3'd2,
        ST_BEYOND    = 3'd3,
        ST_DUPLICATE = 3'd4
    } t_status;

    typedef enum logic {
        KIND_ACK  = 1'b0,
        KIND_DATA = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        CLS_INORDER,
        CLS_AHEAD,
        CLS_LATE,
        CLS_BEYOND
    } t_cls;

    typedef enum logic {
        BK_IDLE,
        BK_DRAIN
    } t_back_state;

    typedef struct packed {
        t_cls                   cls;
        logic [SLOT_BITS-1:0]   offset;
        logic [SEQ_BITS-1:0]    seq;
        logic [HANDLE_BITS-1:0] handle;
        logic                   err;
    } t_cmd;

    typedef struct packed {
        logic                idle;
        logic [SEQ_BITS-1:0] expected_seq;
    } t_back_stat;

endpackage

/* hw/rtl/srb_front.sv */
module srb_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [srb_pkg::S_DATA_BITS-1:0]  s_tdata,  // seq_number, packet_handle
    input  logic [srb_pkg::S_USER_BITS-1:0]  s_tuser,  // is_error
    input  srb_pkg::t_back_stat              i_stat,
    output logic                             o_q_valid,
    output srb_pkg::t_cmd                    o_q_cmd,
    input  logic                             i_q_pop
);

    logic                                r_in_valid;
    logic                                n_in_valid;
    logic [srb_pkg::SEQ_BITS-1:0]        r_in_seq;
    logic [srb_pkg::HANDLE_BITS-1:0]     r_in_handle;
    logic                                r_in_err;
    logic                                r_q_valid;
    logic                                n_q_valid;
    srb_pkg::t_cmd                       r_q_cmd;
    srb_pkg::t_cmd                       n_q_cmd;
    logic                                accept;
    logic                                push;
    logic [srb_pkg::SEQ_BITS-1:0]        seq_gap;

    // classify only against settled state: back idle, queue empty
    assign push     = r_in_valid && !r_q_valid && i_stat.idle;
    assign s_tready = !r_in_valid || push;
    assign accept   = s_tvalid && s_tready;
    assign seq_gap  = r_in_seq - i_stat.expected_seq;

    always_comb begin
        n_q_cmd        = r_q_cmd;
        n_q_cmd.seq    = r_in_seq;
        n_q_cmd.handle = r_in_handle;
        n_q_cmd.err    = r_in_err;
        n_q_cmd.offset = seq_gap[srb_pkg::SLOT_BITS-1:0];
        if (seq_gap == '0) begin
            n_q_cmd.cls = srb_pkg::CLS_INORDER;
        end else if (seq_gap[srb_pkg::SEQ_BITS-1]) begin
            n_q_cmd.cls = srb_pkg::CLS_LATE;
        end else if (seq_gap >= srb_pkg::SEQ_BITS'(srb_pkg::WINDOW)) begin
            n_q_cmd.cls = srb_pkg::CLS_BEYOND;
        end else begin
            n_q_cmd.cls = srb_pkg::CLS_AHEAD;
        end
    end

    always_comb begin
        n_in_valid = r_in_valid;
        if (accept) begin
            n_in_valid = 1'b1;
        end else if (push) begin
            n_in_valid = 1'b0;
        end
        n_q_valid = r_q_valid;
        if (push) begin
            n_q_valid = 1'b1;
        end else if (i_q_pop) begin
            n_q_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_q_valid  <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
            r_q_valid  <= n_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_seq    <= s_tdata[srb_pkg::SEQ_BITS-1:0];
            r_in_handle <= s_tdata[srb_pkg::SEQ_BITS +: srb_pkg::HANDLE_BITS];
            r_in_err    <= s_tuser[0];
        end
        if (push) begin
            r_q_cmd <= n_q_cmd;
        end
    end

    assign o_q_valid = r_q_valid;
    assign o_q_cmd   = r_q_cmd;

    a_push_needs_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_q_valid) |-> $past(i_stat.idle))
        else $error("command queued while back end busy");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> r_q_valid)
        else $error("pop from empty command queue");

    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_q_valid) |=> r_in_valid)
        else $error("pending request lost");

endmodule

/* hw/rtl/srb_back.sv */
module srb_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_q_valid,
    input  srb_pkg::t_cmd                    i_q_cmd,
    output logic                             o_q_pop,
    output srb_pkg::t_back_stat              o_stat,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [srb_pkg::M_DATA_BITS-1:0]  m_tdata,  // seq_out, handle_out, status, zero pad
    output logic [srb_pkg::M_USER_BITS-1:0]  m_tuser,  // kind, error_out
    output logic                             m_tlast
);

    srb_pkg::t_back_state                r_state;
    srb_pkg::t_back_state                n_state;
    logic [srb_pkg::SEQ_BITS-1:0]        r_expected;
    logic [srb_pkg::SEQ_BITS-1:0]        n_expected;
    logic [srb_pkg::SLOT_BITS-1:0]       r_head;
    logic [srb_pkg::SLOT_BITS-1:0]       n_head;
    logic [srb_pkg::WINDOW-1:0]          r_slot_valid;
    logic [srb_pkg::WINDOW-1:0]          n_slot_valid;
    logic [srb_pkg::HANDLE_BITS-1:0]     r_slot_handle [srb_pkg::WINDOW];
    logic                                r_slot_err    [srb_pkg::WINDOW];

    logic [srb_pkg::SEQ_BITS-1:0]        r_w_seq;
    logic [srb_pkg::SEQ_BITS-1:0]        n_w_seq;
    logic [srb_pkg::HANDLE_BITS-1:0]     r_w_handle;
    logic [srb_pkg::HANDLE_BITS-1:0]     n_w_handle;
    logic                                r_w_err;
    logic                                n_w_err;

    logic                                r_m_valid;
    logic                                n_m_valid;
    srb_pkg::t_kind                      r_m_kind;
    srb_pkg::t_kind                      n_m_kind;
    logic [srb_pkg::SEQ_BITS-1:0]        r_m_seq;
    logic [srb_pkg::SEQ_BITS-1:0]        n_m_seq;
    logic [srb_pkg::HANDLE_BITS-1:0]     r_m_handle;
    logic [srb_pkg::HANDLE_BITS-1:0]     n_m_handle;
    logic                                r_m_err;
    logic                                n_m_err;
    srb_pkg::t_status                    r_m_status;
    srb_pkg::t_status                    n_m_status;
    logic                                r_m_last;
    logic                                n_m_last;

    logic                                out_free;
    logic                                take;
    logic [srb_pkg::SLOT_BITS:0]         slot_sum;
    logic [srb_pkg::SLOT_BITS-1:0]       store_idx;
    logic [srb_pkg::SLOT_BITS-1:0]       head_inc;
    logic                                dup;
    logic                                next_valid;
    logic                                wr_store;
    srb_pkg::t_status                    ack_status;

    assign out_free = !r_m_valid || m_tready;
    assign take     = (r_state == srb_pkg::BK_IDLE) && i_q_valid && out_free;
    assign o_q_pop  = take;

    assign slot_sum  = {1'b0, r_head} + {1'b0, i_q_cmd.offset};
    assign store_idx = (slot_sum >= (srb_pkg::SLOT_BITS+1)'(srb_pkg::WINDOW))
                     ? srb_pkg::SLOT_BITS'(slot_sum - (srb_pkg::SLOT_BITS+1)'(srb_pkg::WINDOW))
                     : slot_sum[srb_pkg::SLOT_BITS-1:0];
    assign head_inc  = (r_head == srb_pkg::SLOT_BITS'(srb_pkg::WINDOW - 1))
                     ? '0 : r_head + 1'b1;
    assign dup        = r_slot_valid[store_idx];
    assign next_valid = r_slot_valid[head_inc];
    assign wr_store   = take && (i_q_cmd.cls == srb_pkg::CLS_AHEAD) && !dup;

    always_comb begin
        unique case (i_q_cmd.cls)
            srb_pkg::CLS_INORDER: ack_status = srb_pkg::ST_IN_ORDER;
            srb_pkg::CLS_AHEAD:   ack_status = dup ? srb_pkg::ST_DUPLICATE : srb_pkg::ST_STORED;
            srb_pkg::CLS_LATE:    ack_status = srb_pkg::ST_LATE;
            srb_pkg::CLS_BEYOND:  ack_status = srb_pkg::ST_BEYOND;
            default:              ack_status = srb_pkg::ST_LATE;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            srb_pkg::BK_IDLE: begin
                if (take && (i_q_cmd.cls == srb_pkg::CLS_INORDER)) begin
                    n_state = srb_pkg::BK_DRAIN;
                end
            end
            srb_pkg::BK_DRAIN: begin
                if (out_free && !next_valid) begin
                    n_state = srb_pkg::BK_IDLE;
                end
            end
            default: n_state = srb_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        n_expected   = r_expected;
        n_head       = r_head;
        n_slot_valid = r_slot_valid;
        n_w_seq      = r_w_seq;
        n_w_handle   = r_w_handle;
        n_w_err      = r_w_err;
        n_m_valid    = out_free ? 1'b0 : r_m_valid;
        n_m_kind     = r_m_kind;
        n_m_seq      = r_m_seq;
        n_m_handle   = r_m_handle;
        n_m_err      = r_m_err;
        n_m_status   = r_m_status;
        n_m_last     = r_m_last;
        unique case (r_state)
            srb_pkg::BK_IDLE: begin
                if (take) begin
                    n_m_valid  = 1'b1;
                    n_m_kind   = srb_pkg::KIND_ACK;
                    n_m_seq    = i_q_cmd.seq;
                    n_m_handle = '0;
                    n_m_err    = 1'b0;
                    n_m_status = ack_status;
                    n_m_last   = (i_q_cmd.cls != srb_pkg::CLS_INORDER);
                    n_w_seq    = i_q_cmd.seq;
                    n_w_handle = i_q_cmd.handle;
                    n_w_err    = i_q_cmd.err;
                    if (wr_store) begin
                        n_slot_valid[store_idx] = 1'b1;
                    end
                end
            end
            srb_pkg::BK_DRAIN: begin
                if (out_free) begin
                    n_m_valid  = 1'b1;
                    n_m_kind   = srb_pkg::KIND_DATA;
                    n_m_seq    = r_w_seq;
                    n_m_handle = r_w_handle;
                    n_m_err    = r_w_err;
                    n_m_status = srb_pkg::ST_IN_ORDER;
                    n_m_last   = !next_valid;
                    n_expected = r_w_seq + 1'b1;
                    n_head     = head_inc;
                    // advance onto the next held packet and free its slot
                    if (next_valid) begin
                        n_w_seq                = r_w_seq + 1'b1;
                        n_w_handle             = r_slot_handle[head_inc];
                        n_w_err                = r_slot_err[head_inc];
                        n_slot_valid[head_inc] = 1'b0;
                    end
                end
            end
            default: begin
                n_m_valid = r_m_valid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= srb_pkg::BK_IDLE;
            r_expected   <= '0;
            r_head       <= '0;
            r_slot_valid <= '0;
            r_m_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_expected   <= n_expected;
            r_head       <= n_head;
            r_slot_valid <= n_slot_valid;
            r_m_valid    <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w_seq    <= n_w_seq;
        r_w_handle <= n_w_handle;
        r_w_err    <= n_w_err;
        r_m_kind   <= n_m_kind;
        r_m_seq    <= n_m_seq;
        r_m_handle <= n_m_handle;
        r_m_err    <= n_m_err;
        r_m_status <= n_m_status;
        r_m_last   <= n_m_last;
        if (wr_store) begin
            r_slot_handle[store_idx] <= i_q_cmd.handle;
            r_slot_err[store_idx]    <= i_q_cmd.err;
        end
    end

    assign o_stat.idle         = (r_state == srb_pkg::BK_IDLE);
    assign o_stat.expected_seq = r_expected;

    assign m_tvalid = r_m_valid;
    assign m_tdata  = {{srb_pkg::M_PAD_BITS{1'b0}}, r_m_status, r_m_handle, r_m_seq};
    assign m_tuser  = {r_m_err, r_m_kind};
    assign m_tlast  = r_m_last;

    a_drain_tracks_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == srb_pkg::BK_DRAIN) |-> (r_w_seq == r_expected))
        else $error("drain sequence out of step with expected number");

    a_head_slot_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == srb_pkg::BK_IDLE) |-> !r_slot_valid[r_head])
        else $error("slot of expected number held while idle");

    a_open_run_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && !r_m_last) |-> (r_state == srb_pkg::BK_DRAIN))
        else $error("unterminated result run with drain finished");

    a_data_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && (r_m_kind == srb_pkg::KIND_DATA)) |-> (r_m_status == srb_pkg::ST_IN_ORDER))
        else $error("delivered packet carries an ack status");

endmodule

/* hw/rtl/sequence_reorder_buffer.sv */
// Receive-side reorder buffer for a 32-bit sequence-numbered packet stream.
// Slave channel: one request per arriving packet; tdata carries the sequence
// number (bits 31:0) and the descriptor handle (47:32), tuser the error flag.
// Master channel: for each request an acknowledgement (kind 0) with a status,
// then, for an in-order packet, the packet itself and every consecutive held
// packet (kind 1). tlast marks the final result of each request.
// Packets up to 15 ahead of the expected number are held in slots; late,
// out-of-window and duplicate packets are dropped and flagged in the ack.
// The ack passes through the input register, the command queue register and
// the output register. The input stage classifies a request only once the
// back end has settled the slot state of the previous request; an in-order
// request holds the back end while it drains through the output register,
// one delivery per cycle while the receiver does not stall.
// Reset clears the expected number to 0 and empties every slot at once.
// When the receiver stalls the output register holds its result, the back
// end stops, and the input side backs up through its one-deep queue.
module sequence_reorder_buffer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [srb_pkg::S_DATA_BITS-1:0]  s_tdata,  // seq_number, packet_handle
    input  logic [srb_pkg::S_USER_BITS-1:0]  s_tuser,  // is_error
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [srb_pkg::M_DATA_BITS-1:0]  m_tdata,  // seq_out, handle_out, status, zero pad
    output logic [srb_pkg::M_USER_BITS-1:0]  m_tuser,  // kind, error_out
    output logic                             m_tlast
);

    logic                 q_valid;
    logic                 q_pop;
    srb_pkg::t_cmd        q_cmd;
    srb_pkg::t_back_stat  stat;

    srb_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .i_stat    (stat),
        .o_q_valid (q_valid),
        .o_q_cmd   (q_cmd),
        .i_q_pop   (q_pop)
    );

    srb_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_q_pop   (q_pop),
        .o_stat    (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
